/* hdl/ys2c_pkg.sv */
// Package with shared types, command codes and constants of the calendar date converter.
`timescale 1ns / 1ps
`default_nettype none

package ys2c_pkg;

   typedef struct packed {
      logic [15:0] base_year;
      logic [31:0] year_seconds;
      logic [15:0] millis;
   } req_type;

   typedef struct packed {
      logic [16:0] cal_year;
      logic [3:0]  cal_month;
      logic [4:0]  cal_day;
      logic [4:0]  cal_hour;
      logic [5:0]  cal_minute;
      logic [5:0]  cal_second;
      logic [2:0]  week_day;
   } rsp_type;

   localparam int OP_WIDTH = 5;

   localparam logic [OP_WIDTH-1:0] OP_HOLD  = 5'd0;
   localparam logic [OP_WIDTH-1:0] OP_LOAD  = 5'd1;
   localparam logic [OP_WIDTH-1:0] OP_PREP  = 5'd2;
   localparam logic [OP_WIDTH-1:0] OP_FIX   = 5'd3;
   localparam logic [OP_WIDTH-1:0] OP_YEAR  = 5'd4;
   localparam logic [OP_WIDTH-1:0] OP_MONTH = 5'd5;
   localparam logic [OP_WIDTH-1:0] OP_MSUB  = 5'd6;
   localparam logic [OP_WIDTH-1:0] OP_DDIV  = 5'd7;
   localparam logic [OP_WIDTH-1:0] OP_DREM  = 5'd8;
   localparam logic [OP_WIDTH-1:0] OP_HDIV  = 5'd9;
   localparam logic [OP_WIDTH-1:0] OP_HREM  = 5'd10;
   localparam logic [OP_WIDTH-1:0] OP_MDIV  = 5'd11;
   localparam logic [OP_WIDTH-1:0] OP_MREM  = 5'd12;
   localparam logic [OP_WIDTH-1:0] OP_WDIV  = 5'd13;
   localparam logic [OP_WIDTH-1:0] OP_WSUM  = 5'd14;
   localparam logic [OP_WIDTH-1:0] OP_WQ    = 5'd15;
   localparam logic [OP_WIDTH-1:0] OP_WREM  = 5'd16;
   localparam logic [OP_WIDTH-1:0] OP_ZERO  = 5'd17;

   typedef struct packed {
      logic [OP_WIDTH-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic base_zero;
      logic year_end;
      logic month_end;
   } status_type;

   localparam logic [31:0] DAY_SECS       = 32'd86400;
   localparam logic [31:0] YEAR_SECS      = 32'd31536000;
   localparam logic [31:0] LEAP_YEAR_SECS = 32'd31622400;

   // Reciprocals for division by constants, each with its right shift.
   localparam int unsigned MS_RECIP   = 67109;   // x / 1000, shift 26
   localparam int unsigned Y400_RECIP = 83887;   // x / 400, shift 25
   localparam int unsigned DAY_RECIP  = 49711;   // (x >> 7) / 675, shift 25
   localparam int unsigned HOUR_RECIP = 9321;    // (x >> 4) / 225, shift 21
   localparam int unsigned MIN_RECIP  = 1093;    // (x >> 2) / 15, shift 14
   localparam int unsigned C100_RECIP = 20972;   // (x >> 2) / 25, shift 19
   localparam int unsigned WEEK_RECIP = 149797;  // x / 7, shift 20

   // Start of month (index 0 is January) in seconds, with the leap day from March on.
   function automatic logic [31:0] month_offset(input logic [3:0] idx, input logic lp);
      logic [31:0] base;
      logic [31:0] extra;
      unique case (idx)
         4'd0:    base = 32'd0;
         4'd1:    base = 32'd2678400;
         4'd2:    base = 32'd5097600;
         4'd3:    base = 32'd7776000;
         4'd4:    base = 32'd10368000;
         4'd5:    base = 32'd13046400;
         4'd6:    base = 32'd15638400;
         4'd7:    base = 32'd18316800;
         4'd8:    base = 32'd20995200;
         4'd9:    base = 32'd23587200;
         4'd10:   base = 32'd26265600;
         4'd11:   base = 32'd28857600;
         default: base = 32'd0;
      endcase
      extra = (lp && (idx >= 4'd2)) ? DAY_SECS : 32'd0;
      return base + extra;
   endfunction

   // Integer part of 3 * (m + 1) / 5 for the shifted month numbers 3 to 14.
   function automatic logic [3:0] zeller_term(input logic [3:0] m);
      logic [3:0] t;
      unique case (m)
         4'd3:    t = 4'd2;
         4'd4:    t = 4'd3;
         4'd5:    t = 4'd3;
         4'd6:    t = 4'd4;
         4'd7:    t = 4'd4;
         4'd8:    t = 4'd5;
         4'd9:    t = 4'd6;
         4'd10:   t = 4'd6;
         4'd11:   t = 4'd7;
         4'd12:   t = 4'd7;
         4'd13:   t = 4'd8;
         4'd14:   t = 4'd9;
         default: t = 4'd0;
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

/* hdl/ys2c_if.sv */
// Valid/ready channel interfaces for requests and responses of the date converter.
`timescale 1ns / 1ps
`default_nettype none

interface ys2c_req_if;
   logic             valid;
   logic             ready;
   ys2c_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ys2c_rsp_if;
   logic             valid;
   logic             ready;
   ys2c_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hdl/ys2c_ctrl.sv */
// Controller state machine that sequences the conversion steps and owns the handshakes.
`timescale 1ns / 1ps
`default_nettype none

module ys2c_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  ys2c_pkg::status_type status,
   output ys2c_pkg::cmd_type   cmd
);
   import ys2c_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_PREP  = 5'd1;
   localparam logic [4:0] S_FIX   = 5'd2;
   localparam logic [4:0] S_YEAR  = 5'd3;
   localparam logic [4:0] S_MONTH = 5'd4;
   localparam logic [4:0] S_MSUB  = 5'd5;
   localparam logic [4:0] S_DDIV  = 5'd6;
   localparam logic [4:0] S_DREM  = 5'd7;
   localparam logic [4:0] S_HDIV  = 5'd8;
   localparam logic [4:0] S_HREM  = 5'd9;
   localparam logic [4:0] S_MDIV  = 5'd10;
   localparam logic [4:0] S_MREM  = 5'd11;
   localparam logic [4:0] S_WDIV  = 5'd12;
   localparam logic [4:0] S_WSUM  = 5'd13;
   localparam logic [4:0] S_WQ    = 5'd14;
   localparam logic [4:0] S_WREM  = 5'd15;
   localparam logic [4:0] S_ZERO  = 5'd16;

   logic [4:0] state_ff;
   logic [4:0] state_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic       out_free;
   logic       publish;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_HOLD;
      publish  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.op   = OP_PREP;
            state_in = status.base_zero ? S_ZERO : S_FIX;
         end
         S_FIX: begin
            cmd.op   = OP_FIX;
            state_in = S_YEAR;
         end
         S_YEAR: begin
            cmd.op = OP_YEAR;
            if (status.year_end) begin
               state_in = S_MONTH;
            end
         end
         S_MONTH: begin
            cmd.op = OP_MONTH;
            if (status.month_end) begin
               state_in = S_MSUB;
            end
         end
         S_MSUB: begin
            cmd.op   = OP_MSUB;
            state_in = S_DDIV;
         end
         S_DDIV: begin
            cmd.op   = OP_DDIV;
            state_in = S_DREM;
         end
         S_DREM: begin
            cmd.op   = OP_DREM;
            state_in = S_HDIV;
         end
         S_HDIV: begin
            cmd.op   = OP_HDIV;
            state_in = S_HREM;
         end
         S_HREM: begin
            cmd.op   = OP_HREM;
            state_in = S_MDIV;
         end
         S_MDIV: begin
            cmd.op   = OP_MDIV;
            state_in = S_MREM;
         end
         S_MREM: begin
            cmd.op   = OP_MREM;
            state_in = S_WDIV;
         end
         S_WDIV: begin
            cmd.op   = OP_WDIV;
            state_in = S_WSUM;
         end
         S_WSUM: begin
            cmd.op   = OP_WSUM;
            state_in = S_WQ;
         end
         S_WQ: begin
            cmd.op   = OP_WQ;
            state_in = S_WREM;
         end
         S_WREM: begin
            if (out_free) begin
               cmd.op   = OP_WREM;
               publish  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_ZERO: begin
            if (out_free) begin
               cmd.op   = OP_ZERO;
               publish  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign out_valid_in = publish || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/ys2c_dpath.sv */
// Datapath with the year walk, month search, constant divisions and weekday arithmetic.
`timescale 1ns / 1ps
`default_nettype none

module ys2c_dpath (
   input  logic                 clock,
   input  ys2c_pkg::cmd_type    cmd,
   input  ys2c_pkg::req_type    req_data,
   output ys2c_pkg::status_type status,
   output ys2c_pkg::rsp_type    rsp_data
);
   import ys2c_pkg::*;

   logic [16:0] year_ff,   year_in;
   logic [31:0] secs_ff,   secs_in;
   logic [15:0] ms_ff,     ms_in;
   logic [8:0]  y400_ff,   y400_in;
   logic [6:0]  msq_ff,    msq_in;
   logic [7:0]  yq_ff,     yq_in;
   logic [3:0]  month_ff,  month_in;
   logic [4:0]  day_ff,    day_in;
   logic [4:0]  hour_ff,   hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [13:0] quot_ff,   quot_in;
   logic [16:0] wsum_ff,   wsum_in;
   rsp_type     rsp_ff,    rsp_in;

   logic [8:0]  leap_mod;
   logic        leap;
   logic [31:0] span;
   logic [31:0] month_start;
   logic [3:0]  month_prev;
   logic [32:0] ms_prod;
   logic [32:0] yq_prod;
   logic [16:0] y400_full;
   logic [30:0] day_prod;
   logic [26:0] hour_prod;
   logic [20:0] min_prod;
   logic [29:0] c100_prod;
   logic [34:0] week_prod;
   logic        early_month;
   logic [16:0] wy;
   logic [3:0]  wm;
   logic [16:0] wsum_calc;
   logic [16:0] wrem_full;
   logic [2:0]  wrem;

   // Year modulo 400 is tracked, with years below 100 read as 19xx for the leap test.
   assign leap_mod = (year_ff < 17'd100) ? (y400_ff + 9'd300) : y400_ff;
   assign leap     = (leap_mod == 9'd0) ||
                     ((leap_mod[1:0] == 2'd0) && (leap_mod != 9'd100) &&
                      (leap_mod != 9'd200) && (leap_mod != 9'd300));
   assign span     = leap ? LEAP_YEAR_SECS : YEAR_SECS;

   assign month_start = month_offset(month_ff, leap);
   assign month_prev  = month_ff - 4'd1;

   assign ms_prod   = {17'd0, ms_ff} * 33'(MS_RECIP);
   assign yq_prod   = {17'd0, year_ff[15:0]} * 33'(Y400_RECIP);
   assign y400_full = {1'b0, year_ff[15:0]} - ({9'd0, yq_ff} * 17'd400);
   assign day_prod  = {16'd0, secs_ff[21:7]} * 31'(DAY_RECIP);
   assign hour_prod = {14'd0, secs_ff[16:4]} * 27'(HOUR_RECIP);
   assign min_prod  = {11'd0, secs_ff[11:2]} * 21'(MIN_RECIP);

   assign early_month = (month_ff <= 4'd2);
   assign wy          = early_month ? (year_ff - 17'd1) : year_ff;
   assign wm          = early_month ? (month_ff + 4'd12) : month_ff;
   assign c100_prod   = {15'd0, wy[16:2]} * 30'(C100_RECIP);
   assign week_prod   = {18'd0, wsum_ff} * 35'(WEEK_RECIP);

   assign wsum_calc = {12'd0, day_ff} + {12'd0, wm, 1'b0} + {13'd0, zeller_term(wm)} +
                      wy + {2'd0, wy[16:2]} + {7'd0, quot_ff[11:2]} + 17'd1 -
                      {5'd0, quot_ff[11:0]};
   assign wrem_full = wsum_ff - ({3'd0, quot_ff} * 17'd7);
   assign wrem      = wrem_full[2:0];

   assign status.base_zero = (year_ff == 17'd0);
   assign status.year_end  = (secs_ff < span);
   assign status.month_end = (month_ff == 4'd12) || (secs_ff < month_start);

   always_comb begin
      year_in   = year_ff;
      secs_in   = secs_ff;
      ms_in     = ms_ff;
      y400_in   = y400_ff;
      msq_in    = msq_ff;
      yq_in     = yq_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      quot_in   = quot_ff;
      wsum_in   = wsum_ff;
      rsp_in    = rsp_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            year_in = {1'b0, req_data.base_year};
            secs_in = req_data.year_seconds;
            ms_in   = req_data.millis;
         end
         OP_PREP: begin
            msq_in = ms_prod[32:26];
            yq_in  = yq_prod[32:25];
         end
         OP_FIX: begin
            secs_in = secs_ff + {25'd0, msq_ff};
            y400_in = y400_full[8:0];
         end
         OP_YEAR: begin
            month_in = 4'd1;
            if (!status.year_end) begin
               secs_in = secs_ff - span;
               year_in = year_ff + 17'd1;
               y400_in = (y400_ff == 9'd399) ? 9'd0 : (y400_ff + 9'd1);
            end
         end
         OP_MONTH: begin
            if (!status.month_end) begin
               month_in = month_ff + 4'd1;
            end
         end
         OP_MSUB: begin
            secs_in = secs_ff - month_offset(month_prev, leap);
         end
         OP_DDIV: begin
            quot_in = {9'd0, day_prod[29:25]};
         end
         OP_DREM: begin
            day_in  = quot_ff[4:0] + 5'd1;
            secs_in = secs_ff - ({27'd0, quot_ff[4:0]} * DAY_SECS);
         end
         OP_HDIV: begin
            quot_in = {9'd0, hour_prod[25:21]};
         end
         OP_HREM: begin
            hour_in = quot_ff[4:0];
            secs_in = secs_ff - ({27'd0, quot_ff[4:0]} * 32'd3600);
         end
         OP_MDIV: begin
            quot_in = {8'd0, min_prod[19:14]};
         end
         OP_MREM: begin
            minute_in = quot_ff[5:0];
            secs_in   = secs_ff - ({26'd0, quot_ff[5:0]} * 32'd60);
         end
         OP_WDIV: begin
            quot_in = {4'd0, c100_prod[28:19]};
         end
         OP_WSUM: begin
            wsum_in = wsum_calc;
         end
         OP_WQ: begin
            quot_in = week_prod[33:20];
         end
         OP_WREM: begin
            rsp_in.cal_year   = year_ff;
            rsp_in.cal_month  = month_ff;
            rsp_in.cal_day    = day_ff;
            rsp_in.cal_hour   = hour_ff;
            rsp_in.cal_minute = minute_ff;
            rsp_in.cal_second = secs_ff[5:0];
            rsp_in.week_day   = (wrem == 3'd0) ? 3'd7 : wrem;
         end
         OP_ZERO: begin
            rsp_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      year_ff   <= year_in;
      secs_ff   <= secs_in;
      ms_ff     <= ms_in;
      y400_ff   <= y400_in;
      msq_ff    <= msq_in;
      yq_ff     <= yq_in;
      month_ff  <= month_in;
      day_ff    <= day_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      quot_ff   <= quot_in;
      wsum_ff   <= wsum_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

/* hdl/year_seconds_to_calendar_date.sv */
// Top level of the seconds to Gregorian calendar date converter.
//
// Channel   Direction  Contents
// req_ch    in         base_year, year_seconds, millis
// rsp_ch    out        cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_second, week_day
//
// One transaction is converted at a time. The datapath walks the years serially and then
// tests the months one at a time, before the day, hour, minute and weekday steps. A stamp
// with base year 0 skips these steps and gives an all-zero response. The next request can
// be accepted in the same cycle as the response turns valid.
// Reset is synchronous and clears the controller and the response valid flag.
// A new request is taken while a finished response still waits; the last step stalls
// only until the response register is free.
`timescale 1ns / 1ps
`default_nettype none

module year_seconds_to_calendar_date (
   input  logic          clock,
   input  logic          reset,
   ys2c_req_if.sink      req_ch,
   ys2c_rsp_if.source    rsp_ch
);
   import ys2c_pkg::*;

   cmd_type    cmd;
   status_type status;

   ys2c_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ys2c_dpath u_dpath (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_ch.payload),
      .status   (status),
      .rsp_data (rsp_ch.payload)
   );

endmodule

`default_nettype wire
